// File: rtl/cda_pkg.sv
// cda_pkg: field widths, calendar constants, action codes and the month-length
// decoder for the calendar date/time adder.
// No dependencies; used by cda_leap and calendar_datetime_adder.
package cda_pkg;

    localparam int ACT_W  = 3;
    localparam int AMT_W  = 13;
    localparam int YEAR_W = 16;
    localparam int MON_W  = 4;
    localparam int DAY_W  = 5;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;

    // shared adder and work register widths
    localparam int SW = 18;
    localparam int TW = 14;
    localparam int DW = 14;
    localparam int CW = 9;

    localparam logic signed [SW-1:0] YEAR_MAX  = 18'sd32767;
    localparam logic signed [SW-1:0] YEAR_MIN  = -18'sd32768;
    localparam logic signed [SW-1:0] MIN_SPAN  = 18'sd60;
    localparam logic signed [SW-1:0] HOUR_SPAN = 18'sd24;
    localparam logic signed [SW-1:0] MONTHS    = 18'sd12;

    localparam logic signed [YEAR_W-1:0] YEAR_RST = 16'sd2000;

    // floor(a/25) = (a * 5243) >> 17 for a up to 32768
    localparam int             RECIP_W  = 13;
    localparam logic [RECIP_W-1:0] RECIP25 = 13'd5243;
    localparam int             RECIP_SH = 17;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD  = 3'd0,
        ACT_SEC   = 3'd1,
        ACT_MIN   = 3'd2,
        ACT_HOUR  = 3'd3,
        ACT_DAY   = 3'd4,
        ACT_MONTH = 3'd5,
        ACT_YEAR  = 3'd6
    } t_action;

    // days in month; zero for a month outside 1..12
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MON_W-1:0] m);
        logic [DAY_W-1:0] len;
        unique case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// File: rtl/cda_leap.sv
// cda_leap: three-stage leap-year unit (4/100/400 rule on the magnitude of
// the year). Result held until the next start. Depends on cda_pkg.
module cda_leap
    import cda_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [YEAR_W-1:0] i_year,
    output logic                     o_done,
    output logic                     o_leap
);

    logic [YEAR_W-1:0]         r_abs;
    logic [YEAR_W-1:0]         r_abs2;
    logic [YEAR_W+RECIP_W-1:0] r_prod;
    logic                      r_v1;
    logic                      r_v2;
    logic                      r_v3;
    logic                      r_leap;

    logic [YEAR_W+RECIP_W-RECIP_SH-1:0] q;
    logic [YEAR_W-1:0]                  q25;
    logic [YEAR_W-1:0]                  rem25;
    logic                               leap;

    assign q     = r_prod[YEAR_W+RECIP_W-1:RECIP_SH];
    assign q25   = (YEAR_W'(q) << 4) + (YEAR_W'(q) << 3) + YEAR_W'(q);
    assign rem25 = r_abs2 - q25;
    // divisible by 4, and either not by 100 or by 400
    assign leap  = (r_abs2[1:0] == 2'b00) &&
                   ((rem25 != '0) || (r_abs2[3:0] == 4'b0000));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_leap <= 1'b1;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (i_start) begin
                r_abs <= i_year[YEAR_W-1] ? YEAR_W'(-i_year) : YEAR_W'(i_year);
            end
            if (r_v1) begin
                r_prod <= r_abs * RECIP25;
                r_abs2 <= r_abs;
            end
            if (r_v2) begin
                r_leap <= leap;
            end
        end
    end

    assign o_done = r_v3;
    assign o_leap = r_leap;

endmodule

// File: rtl/calendar_datetime_adder.sv
// calendar_datetime_adder: Gregorian date/time register with signed add per unit.
// One shared adder under a sequencer; leap flag from cda_leap.
// Depends on cda_pkg and cda_leap.
//
// Input channel (i_valid / o_stall): an item is taken when i_valid is high and
// o_stall is low. Action load stores the six load fields unchecked; the add
// actions add i_amount (clamped to +/-MAX_AMOUNT) in seconds, minutes, hours,
// days, months or years, carries and borrows rippling upward; an unused code keeps the date.
// Output channel (o_valid / i_stall): one result item per input item, the full
// date/time after the operation plus o_year_saturated.
// A load or a nonzero year add ends in the leap unit, which runs after every
// load and every year or month change. A second/minute/hour add folds one
// carry or borrow per step, then moves on to each unit that a carry reaches;
// each day carried out of the hour is taken as a single-day step. A day add
// walks one month edge at a time, through the leap unit at each; a month add
// wraps twelve months at a time, stepping the year on each wrap.
// o_stall is high from acceptance until the result moves into the output
// register; a stalled result does not hold off the next item, only the end
// of the one after it.
// Reset: 2000-01-01 00:00:00, output empty.
module calendar_datetime_adder
    import cda_pkg::*;
#(
    parameter int MAX_AMOUNT = 4095
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [ACT_W-1:0]         i_action,
    input  logic signed [AMT_W-1:0]  i_amount,
    input  logic signed [YEAR_W-1:0] i_load_year,
    input  logic [MON_W-1:0]         i_load_month,
    input  logic [DAY_W-1:0]         i_load_day,
    input  logic [HOUR_W-1:0]        i_load_hour,
    input  logic [MIN_W-1:0]         i_load_minute,
    input  logic [SEC_W-1:0]         i_load_second,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [YEAR_W-1:0] o_cur_year,
    output logic [MON_W-1:0]         o_cur_month,
    output logic [DAY_W-1:0]         o_cur_day,
    output logic [HOUR_W-1:0]        o_cur_hour,
    output logic [MIN_W-1:0]         o_cur_minute,
    output logic [SEC_W-1:0]         o_cur_second,
    output logic                     o_year_saturated
);

    localparam logic signed [SW-1:0] MAXA = SW'(MAX_AMOUNT);

    typedef enum logic [3:0] {
        S_IDLE, S_FOLD, S_DSTART, S_DAY, S_DSUB, S_MINC, S_MFOLD,
        S_MYEAR, S_LSTART, S_LWAIT, S_DBACK, S_DONE
    } t_state;

    typedef enum logic [1:0] {U_SEC, U_MIN, U_HOUR} t_unit;
    typedef enum logic [1:0] {R_DONE, R_DAY, R_DBACK} t_ret;

    t_state r_state;
    t_unit  r_unit;
    t_ret   r_ret;

    logic signed [YEAR_W-1:0] r_year;
    logic [MON_W-1:0]         r_month;
    logic [DAY_W-1:0]         r_day;
    logic [HOUR_W-1:0]        r_hour;
    logic [MIN_W-1:0]         r_minute;
    logic [SEC_W-1:0]         r_second;
    logic                     r_sat;

    logic signed [TW-1:0] r_t;
    logic signed [DW-1:0] r_d;
    logic signed [CW-1:0] r_c;
    logic                 r_mdir;
    logic                 r_ydir;
    logic                 r_hour_day;

    logic                     r_ovalid;
    logic signed [YEAR_W-1:0] r_cur_year;
    logic [MON_W-1:0]         r_cur_month;
    logic [DAY_W-1:0]         r_cur_day;
    logic [HOUR_W-1:0]        r_cur_hour;
    logic [MIN_W-1:0]         r_cur_minute;
    logic [SEC_W-1:0]         r_cur_second;
    logic                     r_cur_sat;

    logic                 in_acc;
    t_action              act;
    logic signed [SW-1:0] am_ext;
    logic signed [SW-1:0] am;
    logic signed [SW-1:0] op_a;
    logic signed [SW-1:0] op_b;
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] t_ext;
    logic signed [SW-1:0] span;
    logic signed [SW-1:0] md_s;
    logic [DAY_W-1:0]     md;
    logic                 over;
    logic                 under;
    logic                 m_over;
    logic                 m_under;
    logic                 ysat;
    logic signed [YEAR_W-1:0] ynext;
    logic                 leap_start;
    logic                 leap_done;
    logic                 leap;

    assign in_acc = i_valid && !o_stall;
    assign act    = t_action'(i_action);

    assign am_ext = SW'(i_amount);
    assign am     = (am_ext > MAXA) ? MAXA : ((am_ext < -MAXA) ? -MAXA : am_ext);

    assign t_ext   = SW'(r_t);
    assign span    = (r_unit == U_HOUR) ? HOUR_SPAN : MIN_SPAN;
    assign over    = t_ext >= span;
    assign under   = t_ext < 0;
    assign m_over  = t_ext > MONTHS;
    assign m_under = t_ext < 1;

    assign md   = month_len(leap, r_month);
    assign md_s = SW'(md);

    // shared adder operand selection
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (r_state)
            S_IDLE: begin
                op_b = am;
                case (act)
                    ACT_SEC:   op_a = SW'(r_second);
                    ACT_MIN:   op_a = SW'(r_minute);
                    ACT_HOUR:  op_a = SW'(r_hour);
                    ACT_MONTH: op_a = SW'(r_month);
                    ACT_YEAR:  op_a = SW'(r_year);
                    default:   op_a = '0;
                endcase
            end
            S_FOLD: begin
                if (over) begin
                    op_a = t_ext;
                    op_b = -span;
                end else if (under) begin
                    op_a = t_ext;
                    op_b = span;
                end else begin
                    // carry into the next unit up
                    op_a = (r_unit == U_SEC) ? SW'(r_minute) : SW'(r_hour);
                    op_b = SW'(r_c);
                end
            end
            S_DAY: begin
                op_a = SW'(r_day);
                op_b = SW'(r_d);
            end
            S_DSUB: begin
                op_a = SW'(r_d);
                op_b = -md_s;
            end
            S_DBACK: begin
                op_a = SW'(r_d);
                op_b = md_s;
            end
            S_MINC: begin
                op_a = SW'(r_month);
                op_b = r_mdir ? -18'sd1 : 18'sd1;
            end
            S_MFOLD: begin
                op_a = t_ext;
                op_b = m_over ? -MONTHS : MONTHS;
            end
            S_MYEAR: begin
                op_a = SW'(r_year);
                op_b = r_ydir ? -18'sd1 : 18'sd1;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    assign sum   = op_a + op_b;
    assign ysat  = (sum > YEAR_MAX) || (sum < YEAR_MIN);
    assign ynext = (sum > YEAR_MAX) ? YEAR_W'(YEAR_MAX) :
                   ((sum < YEAR_MIN) ? YEAR_W'(YEAR_MIN) : YEAR_W'(sum));

    assign leap_start = (r_state == S_LSTART);

    cda_leap u_leap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (leap_start),
        .i_year  (r_year),
        .o_done  (leap_done),
        .o_leap  (leap)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_year   <= YEAR_RST;
            r_month  <= 4'd1;
            r_day    <= 5'd1;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_sat    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            // S_DONE refills the output register itself
            if (r_ovalid && !i_stall && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sat      <= 1'b0;
                        r_c        <= '0;
                        r_hour_day <= 1'b0;
                        r_ret      <= R_DONE;
                        unique case (act)
                            ACT_LOAD: begin
                                r_year   <= i_load_year;
                                r_month  <= i_load_month;
                                r_day    <= i_load_day;
                                r_hour   <= i_load_hour;
                                r_minute <= i_load_minute;
                                r_second <= i_load_second;
                                r_state  <= S_LSTART;
                            end
                            ACT_SEC, ACT_MIN, ACT_HOUR: begin
                                r_t    <= TW'(sum);
                                r_unit <= (act == ACT_SEC) ? U_SEC :
                                          ((act == ACT_MIN) ? U_MIN : U_HOUR);
                                r_state <= (am == '0) ? S_DONE : S_FOLD;
                            end
                            ACT_DAY: begin
                                r_d     <= DW'(am);
                                r_state <= S_DAY;
                            end
                            ACT_MONTH: begin
                                r_t     <= TW'(sum);
                                r_state <= (am == '0) ? S_DONE : S_MFOLD;
                            end
                            ACT_YEAR: begin
                                if (am == '0) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_year  <= ynext;
                                    r_sat   <= ysat;
                                    r_state <= S_LSTART;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_FOLD: begin
                    if (over) begin
                        r_t <= TW'(sum);
                        r_c <= r_c + CW'(1);
                    end else if (under) begin
                        r_t <= TW'(sum);
                        r_c <= r_c - CW'(1);
                    end else begin
                        case (r_unit)
                            U_SEC: begin
                                r_second <= SEC_W'(r_t);
                                r_unit   <= U_MIN;
                            end
                            U_MIN: begin
                                r_minute <= MIN_W'(r_t);
                                r_unit   <= U_HOUR;
                            end
                            default: r_hour <= HOUR_W'(r_t);
                        endcase
                        if (r_unit == U_HOUR) begin
                            r_state <= S_DSTART;
                        end else if (r_c == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_t <= TW'(sum);
                            r_c <= '0;
                        end
                    end
                end
                S_DSTART: begin
                    // one single-day step per hour carry
                    if (r_c == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_hour_day <= 1'b1;
                        if (r_c > 0) begin
                            r_d <= DW'(1);
                            r_c <= r_c - CW'(1);
                        end else begin
                            r_d <= -DW'(1);
                            r_c <= r_c + CW'(1);
                        end
                        r_state <= S_DAY;
                    end
                end
                S_DAY: begin
                    if (md == '0) begin
                        r_state <= r_hour_day ? S_DSTART : S_DONE;
                    end else if (r_d > 0 && sum > md_s) begin
                        r_state <= S_DSUB;
                    end else if (r_d < 0 && sum < 1) begin
                        r_mdir  <= 1'b1;
                        r_ret   <= R_DBACK;
                        r_state <= S_MINC;
                    end else begin
                        r_day   <= DAY_W'(sum);
                        r_state <= r_hour_day ? S_DSTART : S_DONE;
                    end
                end
                S_DSUB: begin
                    r_d     <= DW'(sum);
                    r_mdir  <= 1'b0;
                    r_ret   <= R_DAY;
                    r_state <= S_MINC;
                end
                S_MINC: begin
                    r_t     <= TW'(sum);
                    r_state <= S_MFOLD;
                end
                S_MFOLD: begin
                    if (m_over || m_under) begin
                        r_t     <= TW'(sum);
                        r_ydir  <= m_under;
                        r_state <= S_MYEAR;
                    end else begin
                        r_month <= MON_W'(r_t);
                        r_state <= S_LSTART;
                    end
                end
                S_MYEAR: begin
                    // year held at its bound while the month keeps wrapping
                    r_year <= ynext;
                    if (ysat) begin
                        r_sat <= 1'b1;
                    end
                    r_state <= S_MFOLD;
                end
                S_LSTART: r_state <= S_LWAIT;
                S_LWAIT: begin
                    if (leap_done) begin
                        unique case (r_ret)
                            R_DAY:   r_state <= S_DAY;
                            R_DBACK: r_state <= S_DBACK;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_DBACK: begin
                    // borrow: add the length of the month just entered
                    r_d     <= DW'(sum);
                    r_state <= S_DAY;
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid     <= 1'b1;
                        r_cur_year   <= r_year;
                        r_cur_month  <= r_month;
                        r_cur_day    <= r_day;
                        r_cur_hour   <= r_hour;
                        r_cur_minute <= r_minute;
                        r_cur_second <= r_second;
                        r_cur_sat    <= r_sat;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ovalid;
    assign o_cur_year       = r_cur_year;
    assign o_cur_month      = r_cur_month;
    assign o_cur_day        = r_cur_day;
    assign o_cur_hour       = r_cur_hour;
    assign o_cur_minute     = r_cur_minute;
    assign o_cur_second     = r_cur_second;
    assign o_year_saturated = r_cur_sat;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("block not busy after taking an item");

    a_leap_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        leap_start |-> ##3 leap_done)
        else $error("leap unit result late");

    a_no_carry_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> (r_c == '0))
        else $error("carry count left over at end of item");

    a_sat_at_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_year_saturated) |->
            (o_cur_year == YEAR_W'(YEAR_MAX) || o_cur_year == YEAR_W'(YEAR_MIN)))
        else $error("saturation flagged with year off its bound");

endmodule

// File: verif/calendar_datetime_adder_test.sv
// calendar_datetime_adder_test: self-checking bench for the calendar date/time adder.
// Issues directed and random loads/adds, predicts each result in-bench and checks it.
// Depends on cda_pkg and calendar_datetime_adder.
module calendar_datetime_adder_test;
    import cda_pkg::*;

    localparam int AMOUNT_LIMIT = 4095;
    localparam int RANDOM_ITEMS = 1100;
    localparam int CALM_TAIL    = 150;
    localparam int LONG_HOLD    = 300;
    localparam int HOLD_AFTER   = 300;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

    typedef struct {
        logic [ACT_W-1:0]         action;
        logic signed [AMT_W-1:0]  amount;
        logic signed [YEAR_W-1:0] year;
        logic [MON_W-1:0]         month;
        logic [DAY_W-1:0]         day;
        logic [HOUR_W-1:0]        hour;
        logic [MIN_W-1:0]         minute;
        logic [SEC_W-1:0]         second;
    } t_dt_request;

    typedef struct {
        logic signed [YEAR_W-1:0] year;
        logic [MON_W-1:0]         month;
        logic [DAY_W-1:0]         day;
        logic [HOUR_W-1:0]        hour;
        logic [MIN_W-1:0]         minute;
        logic [SEC_W-1:0]         second;
        logic                     saturated;
    } t_dt_state;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    logic                     o_stall;
    logic [ACT_W-1:0]         i_action = '0;
    logic signed [AMT_W-1:0]  i_amount = '0;
    logic signed [YEAR_W-1:0] i_load_year = '0;
    logic [MON_W-1:0]         i_load_month = '0;
    logic [DAY_W-1:0]         i_load_day = '0;
    logic [HOUR_W-1:0]        i_load_hour = '0;
    logic [MIN_W-1:0]         i_load_minute = '0;
    logic [SEC_W-1:0]         i_load_second = '0;
    logic                     o_valid;
    logic                     i_stall = 1'b0;
    logic signed [YEAR_W-1:0] o_cur_year;
    logic [MON_W-1:0]         o_cur_month;
    logic [DAY_W-1:0]         o_cur_day;
    logic [HOUR_W-1:0]        o_cur_hour;
    logic [MIN_W-1:0]         o_cur_minute;
    logic [SEC_W-1:0]         o_cur_second;
    logic                     o_year_saturated;

    calendar_datetime_adder #(.MAX_AMOUNT(AMOUNT_LIMIT)) uut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_dt_request pending_requests[$];
    t_dt_state   expected_dates[$];
    t_dt_request in_flight;
    int total_items = 0;
    int accepted = 0;
    int results_seen = 0;
    int mismatches = 0;
    int send_gap = 0;
    int stall_left = 0;
    bit long_hold_done = 0;

    // predicted calendar state
    int  cal_year = 2000, cal_month = 1, cal_day = 1;
    int  cal_hour = 0, cal_minute = 0, cal_second = 0;
    bit  year_clipped;

    function automatic void shift_year(int delta);
        int y;
        y = cal_year + delta;
        if (y > int'(YEAR_MAX)) begin
            y = int'(YEAR_MAX);
            year_clipped = 1'b1;
        end
        if (y < int'(YEAR_MIN)) begin
            y = int'(YEAR_MIN);
            year_clipped = 1'b1;
        end
        cal_year = y;
    endfunction

    function automatic int days_in(int y, int m);
        int a;
        bit leap;
        a = (y < 0) ? -y : y;
        leap = (a % 4 == 0) && ((a % 100 != 0) || (a % 400 == 0));
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

    function automatic void shift_months(int delta);
        int t;
        if (delta == 0)
            return;
        t = cal_month + delta;
        while (t > int'(MONTHS)) begin
            t -= int'(MONTHS);
            shift_year(1);
        end
        while (t < 1) begin
            t += int'(MONTHS);
            shift_year(-1);
        end
        cal_month = t;
    endfunction

    // month-by-month walk; stops once the rest no longer crosses a month edge, or at a month outside 1..12
    function automatic void shift_days(int delta);
        int md;
        forever begin
            md = days_in(cal_year, cal_month);
            if (md == 0)
                return;
            if (delta > 0 && cal_day + delta > md) begin
                delta -= md;
                shift_months(1);
            end else if (delta < 0 && cal_day + delta < 1) begin
                shift_months(-1);
                delta += days_in(cal_year, cal_month);
            end else begin
                cal_day += delta;
                return;
            end
        end
    endfunction

    // returns the carry count, folded value through nv
    function automatic int wrap_unit(input int v, input int a, input int span, output int nv);
        int t;
        int c;
        c = 0;
        nv = v;
        if (a == 0)
            return 0;
        t = v + a;
        while (t > span - 1) begin
            t -= span;
            c++;
        end
        while (t < 0) begin
            t += span;
            c--;
        end
        nv = t;
        return c;
    endfunction

    function automatic void shift_hours(int a);
        int c;
        c = wrap_unit(cal_hour, a, int'(HOUR_SPAN), cal_hour);
        // every hour carry is its own one-day step
        while (c > 0) begin
            shift_days(1);
            c--;
        end
        while (c < 0) begin
            shift_days(-1);
            c++;
        end
    endfunction

    function automatic t_dt_state apply_datetime_op(t_dt_request req);
        t_dt_state res;
        int amt;
        int c;
        amt = int'(req.amount);
        if (amt > AMOUNT_LIMIT) amt = AMOUNT_LIMIT;
        if (amt < -AMOUNT_LIMIT) amt = -AMOUNT_LIMIT;
        year_clipped = 1'b0;
        case (req.action)
            ACT_LOAD: begin
                cal_year   = int'(req.year);
                cal_month  = int'(req.month);
                cal_day    = int'(req.day);
                cal_hour   = int'(req.hour);
                cal_minute = int'(req.minute);
                cal_second = int'(req.second);
            end
            ACT_SEC: begin
                c = wrap_unit(cal_second, amt, int'(MIN_SPAN), cal_second);
                shift_hours(wrap_unit(cal_minute, c, int'(MIN_SPAN), cal_minute));
            end
            ACT_MIN:   shift_hours(wrap_unit(cal_minute, amt, int'(MIN_SPAN), cal_minute));
            ACT_HOUR:  shift_hours(amt);
            ACT_DAY:   shift_days(amt);
            ACT_MONTH: shift_months(amt);
            ACT_YEAR:  if (amt != 0) shift_year(amt);
            default: ;
        endcase
        res.year      = YEAR_W'(cal_year);
        res.month     = MON_W'(cal_month);
        res.day       = DAY_W'(cal_day);
        res.hour      = HOUR_W'(cal_hour);
        res.minute    = MIN_W'(cal_minute);
        res.second    = SEC_W'(cal_second);
        res.saturated = year_clipped;
        return res;
    endfunction

    task automatic queue_load(int y, int m, int d, int h, int mi, int s);
        t_dt_request r;
        r.action = ACT_LOAD;
        r.amount = AMT_W'($urandom);
        r.year   = YEAR_W'(y);
        r.month  = MON_W'(m);
        r.day    = DAY_W'(d);
        r.hour   = HOUR_W'(h);
        r.minute = MIN_W'(mi);
        r.second = SEC_W'(s);
        pending_requests.push_back(r);
    endtask

    // load fields carry random junk on adds
    task automatic queue_add(logic [ACT_W-1:0] act, int amt);
        t_dt_request r;
        r.action = act;
        r.amount = AMT_W'(amt);
        r.year   = YEAR_W'($urandom);
        r.month  = MON_W'($urandom);
        r.day    = DAY_W'($urandom);
        r.hour   = HOUR_W'($urandom);
        r.minute = MIN_W'($urandom);
        r.second = SEC_W'($urandom);
        pending_requests.push_back(r);
    endtask

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : driver
        bit taken;
        taken = i_valid && !o_stall;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (taken) begin
                expected_dates.push_back(apply_datetime_op(in_flight));
                accepted++;
                if (accepted < total_items - CALM_TAIL && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 11);
            end
            // a stalled item stays put
            if (taken || !i_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    in_flight = pending_requests.pop_front();
                    i_action      <= in_flight.action;
                    i_amount      <= in_flight.amount;
                    i_load_year   <= in_flight.year;
                    i_load_month  <= in_flight.month;
                    i_load_day    <= in_flight.day;
                    i_load_hour   <= in_flight.hour;
                    i_load_minute <= in_flight.minute;
                    i_load_second <= in_flight.second;
                    i_valid       <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            // one long hold-off so the block backs up into its input
            if (stall_left == 0 && !long_hold_done && results_seen >= HOLD_AFTER) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && accepted < total_items - CALM_TAIL &&
                         $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 11);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_dt_state want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_dates.size() == 0) begin
                report_mismatch("result with nothing outstanding", int'(o_cur_year), 0);
            end else begin
                want = expected_dates.pop_front();
                if (o_cur_year !== want.year)
                    report_mismatch("year", int'(o_cur_year), int'(want.year));
                if (o_cur_month !== want.month)
                    report_mismatch("month", int'(o_cur_month), int'(want.month));
                if (o_cur_day !== want.day)
                    report_mismatch("day", int'(o_cur_day), int'(want.day));
                if (o_cur_hour !== want.hour)
                    report_mismatch("hour", int'(o_cur_hour), int'(want.hour));
                if (o_cur_minute !== want.minute)
                    report_mismatch("minute", int'(o_cur_minute), int'(want.minute));
                if (o_cur_second !== want.second)
                    report_mismatch("second", int'(o_cur_second), int'(want.second));
                if (o_year_saturated !== want.saturated)
                    report_mismatch("year_saturated", int'(o_year_saturated),
                                    int'(want.saturated));
            end
        end
    end

    initial begin : main
        int k;
        int sel;
        int mag;
        int amt;
        int y;
        int m;
        // directed: leap rules, borrows, saturation, invalid fields, clamping
        queue_load(2000, 2, 29, 23, 59, 59);
        queue_add(ACT_SEC, 1);
        queue_load(1900, 2, 28, 23, 59, 59);
        queue_add(ACT_SEC, 1);
        queue_add(ACT_DAY, -1);
        queue_load(2024, 1, 31, 12, 30, 30);
        queue_add(ACT_MONTH, 1);
        queue_add(ACT_DAY, 4095);
        queue_add(ACT_DAY, -4096);
        queue_load(32767, 12, 31, 23, 59, 59);
        queue_add(ACT_SEC, 1);
        queue_add(ACT_YEAR, 4095);
        queue_load(-32768, 1, 1, 0, 0, 0);
        queue_add(ACT_MIN, -1);
        queue_add(ACT_HOUR, 4095);
        queue_load(-400, 0, 31, 31, 63, 63);
        queue_add(ACT_DAY, 5);
        queue_add(ACT_SEC, 0);
        queue_add(ACT_SEC, 1);
        queue_add(ACT_MIN, -1);
        queue_add(ACT_HOUR, 1);
        queue_add(ACT_MONTH, -4095);
        queue_add(ACT_YEAR, 0);
        queue_add(ACT_UNUSED, 77);
        queue_add(ACT_SEC, -4096);

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 12) begin
                case ($urandom_range(0, 7))
                    0: y = 2000;
                    1: y = 1900;
                    2: y = -100;
                    3: y = int'(YEAR_MAX) - $urandom_range(0, 3);
                    4: y = int'(YEAR_MIN) + $urandom_range(0, 3);
                    5: y = $urandom_range(0, 1) ? 0 : -400;
                    default: y = int'($signed(YEAR_W'($urandom)));
                endcase
                m = $urandom_range(1, 12);
                queue_load(y, m, $urandom_range(1, days_in(y, m)), $urandom_range(0, 23),
                           $urandom_range(0, 59), $urandom_range(0, 59));
            end else if (sel < 16) begin
                queue_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else if (sel < 18) begin
                queue_add(ACT_UNUSED, $urandom);
            end else begin
                // mostly small amounts; large ones keep the run long
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: mag = $urandom_range(0, 70);
                    6, 7, 8:          mag = $urandom_range(0, 1000);
                    default:          mag = -1;
                endcase
                if (mag < 0)
                    amt = $urandom;
                else
                    amt = $urandom_range(0, 1) ? -mag : mag;
                queue_add(ACT_W'($urandom_range(ACT_SEC, ACT_YEAR)), amt);
            end
        end
        total_items = pending_requests.size();

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted < total_items || expected_dates.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0)
            $display("[calendar_datetime_adder] OK");
        else
            $display("[calendar_datetime_adder] ERROR");
        $finish;
    end

    initial begin : watchdog
        #20000000;
        $display("[calendar_datetime_adder] ERROR");
        $finish;
    end

endmodule

// File: sim.f
rtl/cda_pkg.sv
rtl/cda_leap.sv
rtl/calendar_datetime_adder.sv
verif/calendar_datetime_adder_test.sv
